/* rtl/core/rgbycc_pkg.sv */
// ============================================================================
// rgbycc_pkg
// Shared types, register codes, sampling-block shapes and coefficient helper
// for the RGB to YCbCr converter with chroma subsampling.
// ============================================================================
package rgbycc_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       chroma_valid;
        logic       end_of_frame;
    } ycc_t;

    typedef struct packed {
        logic chroma_valid;
        logic end_of_frame;
    } pos_flags_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_CHROMA_MODE  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_444 = 3'd0,
        MODE_422 = 3'd1,
        MODE_420 = 3'd2,
        MODE_411 = 3'd3,
        MODE_410 = 3'd4
    } chroma_mode_t;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [2:0]            CHROMA_MODE_RST  = 3'(MODE_444);

    // log2 of block width and height in pixels
    typedef struct packed {
        logic [1:0] col_log2;
        logic [1:0] row_log2;
    } block_shape_t;

    function automatic block_shape_t block_shape(chroma_mode_t mode);
        block_shape_t s;
        case (mode)
            MODE_422: s = '{col_log2: 2'd1, row_log2: 2'd0};
            MODE_420: s = '{col_log2: 2'd1, row_log2: 2'd1};
            MODE_411: s = '{col_log2: 2'd2, row_log2: 2'd0};
            MODE_410: s = '{col_log2: 2'd2, row_log2: 2'd2};
            default:  s = '{col_log2: 2'd0, row_log2: 2'd0};
        endcase
        return s;
    endfunction

    // coefficients in millionths
    localparam longint MICRO_Y_R  = 299000;
    localparam longint MICRO_Y_G  = 587000;
    localparam longint MICRO_Y_B  = 114000;
    localparam longint MICRO_CB_R = 168736;
    localparam longint MICRO_CB_G = 331264;
    localparam longint MICRO_HALF = 500000;
    localparam longint MICRO_CR_G = 418688;
    localparam longint MICRO_CR_B = 81312;

    // round(micro * 2^frac_bits / 1e6), ties away from zero
    function automatic longint qcoef(longint micro, int frac_bits);
        return ((micro << frac_bits) + 64'sd500000) / 64'sd1000000;
    endfunction

endpackage

/* rtl/core/rgbycc_position.sv */
// ============================================================================
// rgbycc_position
// Raster column/row counters; flags chroma sampling points of whole blocks
// and the last pixel of the frame.
// ============================================================================
module rgbycc_position
    import rgbycc_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [CFG_DATA_W-1:0] frame_width,
    input  logic [CFG_DATA_W-1:0] frame_height,
    input  chroma_mode_t          chroma_mode,
    output pos_flags_t            flags
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = CW + 1;
    localparam int LW = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam logic [LW-1:0] MAX_DIM = LW'(MAX_DIMENSION);

    function automatic logic [DW-1:0] clamp_dim(logic [CFG_DATA_W-1:0] v);
        logic [LW-1:0] x;
        x = LW'(v);
        if (x == '0)
            x = LW'(1);
        else if (x > MAX_DIM)
            x = MAX_DIM;
        return x[DW-1:0];
    endfunction

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [DW-1:0] width, height;
    block_shape_t  shape;
    logic [CW-1:0] col_mask, row_mask;
    logic [DW:0]   col_span, row_span;
    logic          fit_col, fit_row, last_col, last_row;

    always_comb
    begin
        width    = clamp_dim(frame_width);
        height   = clamp_dim(frame_height);
        shape    = block_shape(chroma_mode);
        col_mask = ~({CW{1'b1}} << shape.col_log2);
        row_mask = ~({CW{1'b1}} << shape.row_log2);
        col_span = (DW+1)'(1) << shape.col_log2;
        row_span = (DW+1)'(1) << shape.row_log2;
        fit_col  = ((DW+1)'(col_reg) + col_span) <= (DW+1)'(width);
        fit_row  = ((DW+1)'(row_reg) + row_span) <= (DW+1)'(height);
        last_col = DW'(col_reg) >= (width - DW'(1));
        last_row = DW'(row_reg) >= (height - DW'(1));

        flags.chroma_valid = ((col_reg & col_mask) == '0) && ((row_reg & row_mask) == '0)
                             && fit_col && fit_row;
        flags.end_of_frame = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/rgbycc_convert.sv */
// ============================================================================
// rgbycc_convert
// BT.601 full-range color matrix: floored luma, chroma truncated toward zero,
// offset by 128 and clamped; chroma forced to zero off sampling points.
// ============================================================================
module rgbycc_convert
    import rgbycc_pkg::*;
#(
    parameter int COEFF_FRAC_BITS = 16
) (
    input  pixel_t     pixel,
    input  pos_flags_t flags,
    output ycc_t       ycc
);

    localparam int F   = COEFF_FRAC_BITS;
    localparam int CFW = F + 2;
    localparam int PW  = CFW + 9;
    localparam int SW  = PW + 2;
    localparam int QW  = SW - F;

    localparam logic signed [CFW-1:0] Y_R  = CFW'(qcoef(MICRO_Y_R, F));
    localparam logic signed [CFW-1:0] Y_G  = CFW'(qcoef(MICRO_Y_G, F));
    localparam logic signed [CFW-1:0] Y_B  = CFW'(qcoef(MICRO_Y_B, F));
    localparam logic signed [CFW-1:0] CB_R = CFW'(-qcoef(MICRO_CB_R, F));
    localparam logic signed [CFW-1:0] CB_G = CFW'(-qcoef(MICRO_CB_G, F));
    localparam logic signed [CFW-1:0] CB_B = CFW'(qcoef(MICRO_HALF, F));
    localparam logic signed [CFW-1:0] CR_R = CFW'(qcoef(MICRO_HALF, F));
    localparam logic signed [CFW-1:0] CR_G = CFW'(-qcoef(MICRO_CR_G, F));
    localparam logic signed [CFW-1:0] CR_B = CFW'(-qcoef(MICRO_CR_B, F));

    function automatic logic signed [SW-1:0] dot3(
        logic signed [CFW-1:0] c0, logic signed [CFW-1:0] c1, logic signed [CFW-1:0] c2,
        logic signed [8:0] x0, logic signed [8:0] x1, logic signed [8:0] x2);
        logic signed [PW-1:0] p0, p1, p2;
        p0 = c0 * x0;
        p1 = c1 * x1;
        p2 = c2 * x2;
        return SW'(p0) + SW'(p1) + SW'(p2);
    endfunction

    function automatic logic [7:0] chroma_of(logic signed [SW-1:0] s);
        logic [SW-1:0]       mag;
        logic [QW-1:0]       qmag;
        logic signed [QW+1:0] q;
        mag  = s[SW-1] ? SW'(-s) : SW'(s);
        qmag = mag[SW-1:F];
        if (s[SW-1])
            q = $signed((QW+2)'(128) - (QW+2)'(qmag));
        else
            q = $signed((QW+2)'(128) + (QW+2)'(qmag));
        if (q < 0)
            return 8'd0;
        else if (q > 255)
            return 8'd255;
        return q[7:0];
    endfunction

    logic signed [8:0]    r_s, g_s, b_s;
    logic signed [SW-1:0] y_sum, cb_sum, cr_sum;
    logic [QW-1:0]        y_q;

    always_comb
    begin
        r_s    = $signed({1'b0, pixel.red});
        g_s    = $signed({1'b0, pixel.green});
        b_s    = $signed({1'b0, pixel.blue});
        y_sum  = dot3(Y_R, Y_G, Y_B, r_s, g_s, b_s);
        cb_sum = dot3(CB_R, CB_G, CB_B, r_s, g_s, b_s);
        cr_sum = dot3(CR_R, CR_G, CR_B, r_s, g_s, b_s);
        y_q    = y_sum[SW-1:F];

        ycc.luma         = (|y_q[QW-1:8]) ? 8'd255 : y_q[7:0];
        ycc.chroma_blue  = flags.chroma_valid ? chroma_of(cb_sum) : 8'd0;
        ycc.chroma_red   = flags.chroma_valid ? chroma_of(cr_sum) : 8'd0;
        ycc.chroma_valid = flags.chroma_valid;
        ycc.end_of_frame = flags.end_of_frame;
    end

endmodule

/* rtl/core/rgb_to_ycbcr_subsampled_core.sv */
// ============================================================================
// rgb_to_ycbcr_subsampled_core
// Raster RGB pixels to full-range BT.601 YCbCr with point-sampled chroma.
//
// Pixels enter on the pixel channel (valid/ready), one transfer per pixel,
// in raster order. Each pixel gives one transfer on the result channel:
// luma always, chroma_blue/chroma_red with chroma_valid at the top-left pixel
// of each whole sampling block (zero elsewhere), end_of_frame on the last
// pixel of the frame.
// Registers go in on the cfg channel (index, data), always ready; write them
// only while no pixel is in flight.
// The pixel goes from the input register through the color matrix into the
// result register, which holds it as the valid result. Throughput: one pixel
// per cycle while the receiver does not stall, set by the combinational color
// matrix between the two registers.
// When the receiver stalls, both registers fill and pixel_ready drops; it
// rises in the cycle the result is taken.
// Reset clears both stages, the column and row counters, and returns the
// registers to 640 x 480, 4:4:4.
// ============================================================================
module rgb_to_ycbcr_subsampled_core
    import rgbycc_pkg::*;
#(
    parameter int MAX_DIMENSION   = 4096,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  pixel_t                 pixel,
    output logic                   result_valid,
    input  logic                   result_ready,
    output ycc_t                   result
);

    logic [CFG_DATA_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_DATA_W-1:0] frame_height_reg, frame_height_next;
    logic [2:0]            chroma_mode_reg, chroma_mode_next;

    logic       s1_valid_reg, s1_valid_next;
    pixel_t     s1_pixel_reg;
    pos_flags_t s1_flags_reg;
    logic       result_valid_reg, result_valid_next;
    ycc_t       result_reg;

    logic       pixel_xfer, s2_load;
    pos_flags_t pos_flags;
    ycc_t       ycc_next;

    assign cfg_ready    = 1'b1;
    assign s2_load      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign pixel_ready  = !s1_valid_reg || s2_load;
    assign pixel_xfer   = pixel_valid && pixel_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        chroma_mode_next  = chroma_mode_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                REG_CHROMA_MODE:  chroma_mode_next  = cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pixel_xfer)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (s2_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    rgbycc_position #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (pixel_xfer),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .chroma_mode  (chroma_mode_t'(chroma_mode_reg)),
        .flags        (pos_flags)
    );

    rgbycc_convert #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_convert (
        .pixel (s1_pixel_reg),
        .flags (s1_flags_reg),
        .ycc   (ycc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            chroma_mode_reg  <= CHROMA_MODE_RST;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            chroma_mode_reg  <= chroma_mode_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_xfer)
        begin
            s1_pixel_reg <= pixel;
            s1_flags_reg <= pos_flags;
        end
        if (s2_load)
            result_reg <= ycc_next;
    end

    // off sampling points chroma reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.chroma_valid
        |-> result_reg.chroma_blue == 8'd0 && result_reg.chroma_red == 8'd0)
        else $error("chroma nonzero on a non-sampling pixel");

    // input stage never overwritten while still holding a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_xfer && s1_valid_reg |-> s2_load)
        else $error("input stage overrun");

    // a new result only comes from a full input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a pixel");

endmodule
